@@ hw/rtl/omt_pkg.sv @@
// ----------------------------------------------------------------------------
// omt_pkg - shared types and constants for the one-shot timer bank
// Item layouts, command codes, controller states and per-cell slot record.
// ----------------------------------------------------------------------------
`default_nettype none

package omt_pkg;

    // Field widths fixed by the item layouts
    localparam int CH_W   = 3;
    localparam int TICK_W = 16;
    localparam int TAG_W  = 16;
    localparam int CMD_W  = 2;

    // Channels reachable through the channel field
    localparam int ADDRESSABLE      = 1 << CH_W;
    localparam int CHANNELS_DEFAULT = 8;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Request item
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [CH_W-1:0]   channel;
        logic              deliver_by_message;
        logic [TICK_W-1:0] ticks;
        logic [TAG_W-1:0]  handler_tag;
    } req_item_t;

    // Expiry event item
    typedef struct packed {
        logic [CH_W-1:0]  expired_channel;
        logic             expired_mode;
        logic [TAG_W-1:0] expired_tag;
        logic             last_event;
    } evt_item_t;

    // Expiry record held in each cell and shifted towards cell 0
    typedef struct packed {
        logic             valid;
        logic [CH_W-1:0]  channel;
        logic             mode;
        logic [TAG_W-1:0] tag;
    } slot_t;

    // Strobes from the controller to every cell
    typedef struct packed {
        logic tick;
        logic start;
        logic stop;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/omt_cell.sv @@
// ----------------------------------------------------------------------------
// omt_cell - one timer channel of the bank
// Holds count, mode, tag and active flag; on expiry fills its event slot,
// which then shifts down the chain one cell per cycle while shift is strobed.
// ----------------------------------------------------------------------------
`default_nettype none

module omt_cell #(
    parameter int INDEX = 0
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  omt_pkg::cell_ctrl_t            ctrl,
    input  wire  [omt_pkg::CH_W-1:0]       channel,
    input  wire                            deliver_by_message,
    input  wire  [omt_pkg::TICK_W-1:0]     ticks,
    input  wire  [omt_pkg::TAG_W-1:0]      handler_tag,
    input  omt_pkg::slot_t                 slot_up,
    input  wire                            behind_up,
    output omt_pkg::slot_t                 slot,
    output logic                           behind
);

    localparam logic [omt_pkg::CH_W-1:0] MY_CH = omt_pkg::CH_W'(INDEX);

    logic                       active_reg;
    logic                       active_next;
    logic                       mode_reg;
    logic                       mode_next;
    logic [omt_pkg::TICK_W-1:0] remain_reg;
    logic [omt_pkg::TICK_W-1:0] remain_next;
    logic [omt_pkg::TAG_W-1:0]  tag_reg;
    logic [omt_pkg::TAG_W-1:0]  tag_next;
    logic                       slot_valid_reg;
    logic                       slot_valid_next;
    logic                       slot_mode_reg;
    logic                       slot_mode_next;
    logic [omt_pkg::CH_W-1:0]   slot_ch_reg;
    logic [omt_pkg::CH_W-1:0]   slot_ch_next;
    logic [omt_pkg::TAG_W-1:0]  slot_tag_reg;
    logic [omt_pkg::TAG_W-1:0]  slot_tag_next;
    logic                       hit;
    logic                       expire;

    assign hit    = (channel == MY_CH);
    assign expire = ctrl.tick && active_reg && (remain_reg <= omt_pkg::TICK_W'(1));

    // Load, stop and count down the channel
    always_comb
    begin
        active_next = active_reg;
        mode_next   = mode_reg;
        remain_next = remain_reg;
        tag_next    = tag_reg;
        if (ctrl.start && hit)
        begin
            active_next = 1'b1;
            mode_next   = deliver_by_message;
            tag_next    = handler_tag;
            remain_next = (ticks == '0) ? omt_pkg::TICK_W'(1) : ticks;
        end
        else if (ctrl.stop && hit)
        begin
            active_next = 1'b0;
        end
        else if (ctrl.tick && active_reg)
        begin
            if (expire)
            begin
                active_next = 1'b0;
                remain_next = '0;
            end
            else
            begin
                remain_next = remain_reg - omt_pkg::TICK_W'(1);
            end
        end
    end

    // Fill the slot on expiry, otherwise take the upstream neighbour's slot
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        slot_mode_next  = slot_mode_reg;
        slot_ch_next    = slot_ch_reg;
        slot_tag_next   = slot_tag_reg;
        if (ctrl.tick)
        begin
            slot_valid_next = expire;
            slot_mode_next  = mode_reg;
            slot_ch_next    = MY_CH;
            slot_tag_next   = tag_reg;
        end
        else if (ctrl.shift)
        begin
            slot_valid_next = slot_up.valid;
            slot_mode_next  = slot_up.mode;
            slot_ch_next    = slot_up.channel;
            slot_tag_next   = slot_up.tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            mode_reg       <= 1'b0;
            slot_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            mode_reg       <= mode_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        remain_reg    <= remain_next;
        tag_reg       <= tag_next;
        slot_mode_reg <= slot_mode_next;
        slot_ch_reg   <= slot_ch_next;
        slot_tag_reg  <= slot_tag_next;
    end

    assign slot.valid   = slot_valid_reg;
    assign slot.channel = slot_ch_reg;
    assign slot.mode    = slot_mode_reg;
    assign slot.tag     = slot_tag_reg;

    // Any pending record at or beyond this cell
    assign behind = slot_valid_reg || behind_up;

endmodule

`default_nettype wire

@@ hw/rtl/multi_channel_oneshot_timer_unit.sv @@
// ----------------------------------------------------------------------------
// multi_channel_oneshot_timer_unit - bank of one-shot countdown timers
// Start, stop and tick commands drive a chain of timer cells; expiry events
// leave in ascending channel order with the final one of a tick flagged.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  req     | in        | req_valid / req_stall | omt_pkg::req_item_t commands
//  evt     | out       | evt_valid / evt_stall | omt_pkg::evt_item_t expiries
//
//  A tick counts down all channels at once, then the event slots shift one
//  cell per cycle towards cell 0; the chain is empty after one shift more
//  than the highest expiring channel (at most LIVE, which is at most 8), and
//  the bank goes idle in the cycle after that. req_stall is high from the
//  cycle after a tick until then, and evt_stall can hold it high for longer.
//  The chain only shifts when the event register is free or being taken.
//  Reset clears active flags, modes, pending slots and the event valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_oneshot_timer_unit #(
    parameter int CHANNELS = omt_pkg::CHANNELS_DEFAULT
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  omt_pkg::req_item_t  req,
    output logic                evt_valid,
    input  wire                 evt_stall,
    output omt_pkg::evt_item_t  evt
);

    localparam int LIVE = (CHANNELS < omt_pkg::ADDRESSABLE) ? CHANNELS
                                                             : omt_pkg::ADDRESSABLE;

    omt_pkg::state_t     state_reg;
    omt_pkg::state_t     state_next;
    omt_pkg::cell_ctrl_t ctrl;
    omt_pkg::slot_t      slots [LIVE+1];
    logic [LIVE:0]       behind;
    logic                accept;
    logic                advance;
    logic                evt_valid_reg;
    logic                evt_valid_next;
    omt_pkg::evt_item_t  evt_reg;
    omt_pkg::evt_item_t  evt_next;

    assign accept  = req_valid && !req_stall;
    assign advance = !evt_valid_reg || !evt_stall;

    // Command decode into per-cell strobes
    always_comb
    begin
        ctrl.tick  = accept && (req.command == omt_pkg::CMD_TICK);
        ctrl.start = accept && (req.command == omt_pkg::CMD_START);
        ctrl.stop  = accept && (req.command == omt_pkg::CMD_STOP);
        ctrl.shift = (state_reg == omt_pkg::ST_SCAN) && advance;
    end

    // Terminate the far end of the chain
    assign slots[LIVE]  = '0;
    assign behind[LIVE] = 1'b0;

    // Row of timer cells
    for (genvar i = 0; i < LIVE; i++)
    begin : g_cell
        omt_cell #(
            .INDEX(i)
        ) u_cell (
            .clk                (clk),
            .rst_n              (rst_n),
            .ctrl               (ctrl),
            .channel            (req.channel),
            .deliver_by_message (req.deliver_by_message),
            .ticks              (req.ticks),
            .handler_tag        (req.handler_tag),
            .slot_up            (slots[i+1]),
            .behind_up          (behind[i+1]),
            .slot               (slots[i]),
            .behind             (behind[i])
        );
    end

    // Sequence: idle until a tick, then drain the chain
    always_comb
    begin
        state_next     = state_reg;
        evt_valid_next = evt_valid_reg && evt_stall;
        evt_next       = evt_reg;
        req_stall      = (state_reg == omt_pkg::ST_SCAN);
        unique case (state_reg)
            omt_pkg::ST_IDLE:
            begin
                if (ctrl.tick)
                begin
                    state_next = omt_pkg::ST_SCAN;
                end
            end
            omt_pkg::ST_SCAN:
            begin
                if (!behind[0])
                begin
                    state_next = omt_pkg::ST_IDLE;
                end
                else if (advance && slots[0].valid)
                begin
                    evt_valid_next           = 1'b1;
                    evt_next.expired_channel = slots[0].channel;
                    evt_next.expired_mode    = slots[0].mode;
                    evt_next.expired_tag     = slots[0].tag;
                    evt_next.last_event      = !behind[1];
                end
            end
            default:
            begin
                state_next = omt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= omt_pkg::ST_IDLE;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    // Event payload, no reset
    always_ff @(posedge clk)
    begin
        evt_reg <= evt_next;
    end

    assign evt_valid = evt_valid_reg;
    assign evt       = evt_reg;

    // The chain holds no records while idle
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == omt_pkg::ST_IDLE) |-> !behind[0])
        else $error("expiry records left in chain while idle");

    // A flagged final event leaves the chain empty
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.shift && slots[0].valid && !behind[1]) |=> !behind[0])
        else $error("records remain after final event");

    // A tick always starts a drain pass
    a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.tick |=> (state_reg == omt_pkg::ST_SCAN))
        else $error("tick did not start drain");

    // Records never reach the output while it is stalled and full
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid_reg && evt_stall) |-> !ctrl.shift)
        else $error("chain shifted into a stalled event register");

endmodule

`default_nettype wire
